FILE: src/tse_pkg.sv
// Shared widths, codes and bus types for the Taylor series evaluator.
package tse_pkg;

  localparam int DATA_W     = 48;
  localparam int ARG_W      = 32;
  localparam int CNT_W      = 6;
  localparam int RECIP_BITS = 32;
  localparam int RCP_W      = RECIP_BITS + 1;
  localparam int DIGIT_W    = 16;
  localparam int NUM_CELLS  = DATA_W / DIGIT_W;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int LO_W       = 64;
  localparam int IN_DATA_W  = 40;

  localparam int DEF_MAX_TERMS = 32;
  localparam int DEF_FRAC_BITS = 28;

  typedef enum logic {
    SH_FRAC,
    SH_RECIP
  } shift_sel_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    shift_sel_t               sel;
  } mul_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ovf;
  } mul_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic              neg;
    shift_sel_t        sel;
    logic [PROD_W-1:0] acc;
  } cell_bus_t;

endpackage

FILE: src/tse_cell.sv
// One multiplier cell: adds the product with one digit of b into the running sum.
module tse_cell
  import tse_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cell_bus_t in_bus,
  output logic      out_valid,
  output cell_bus_t out_bus
);

  logic [DIGIT_W-1:0]        digit;
  logic [DATA_W+DIGIT_W-1:0] pp;
  cell_bus_t                 bus_nxt;

  assign digit = in_bus.b_mag[IDX*DIGIT_W +: DIGIT_W];
  assign pp    = in_bus.a_mag * digit;

  always_comb begin
    bus_nxt     = in_bus;
    bus_nxt.acc = in_bus.acc + (PROD_W'(pp) << (IDX * DIGIT_W));
  end

  always_ff @(posedge clk) begin
    out_bus <= bus_nxt;
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

FILE: src/tse_mul.sv
// Pipelined signed multiplier: a row of digit cells, then round, shift and saturate.
module tse_mul
  import tse_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  input  mul_req_t req,
  output logic     res_valid,
  output mul_res_t res
);

  localparam logic [PROD_W-1:0] HALF_FRAC = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] HALF_RCP  = PROD_W'(1) << (RECIP_BITS - 1);
  localparam logic [PROD_W-1:0] LIM_NEG   = PROD_W'(1) << (DATA_W - 1);
  localparam logic [PROD_W-1:0] LIM_POS   = LIM_NEG - PROD_W'(1);

  cell_bus_t            bus [NUM_CELLS+1];
  logic [NUM_CELLS:0]   vld;
  cell_bus_t            bus0_r;
  logic                 vld0_r;
  logic [DATA_W-1:0]    ua, ub;
  cell_bus_t            bus0_nxt;
  logic [PROD_W-1:0]    q, lim;
  logic                 negq, sat;
  logic [DATA_W-1:0]    mag;
  mul_res_t             res_nxt;

  assign ua = req.a;
  assign ub = req.b;

  always_comb begin
    bus0_nxt.a_mag = ua[DATA_W-1] ? (~ua + 1'b1) : ua;
    bus0_nxt.b_mag = ub[DATA_W-1] ? (~ub + 1'b1) : ub;
    bus0_nxt.neg   = ua[DATA_W-1] ^ ub[DATA_W-1];
    bus0_nxt.sel   = req.sel;
    bus0_nxt.acc   = (req.sel == SH_RECIP) ? HALF_RCP : HALF_FRAC;
  end

  always_ff @(posedge clk) begin
    bus0_r <= bus0_nxt;
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= req_valid;
    end
  end

  assign bus[0] = bus0_r;
  assign vld[0] = vld0_r;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tse_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_bus   (bus[i]),
      .out_valid(vld[i+1]),
      .out_bus  (bus[i+1])
    );
  end

  // round already folded into the starting sum; here shift, clamp, restore sign
  always_comb begin
    q    = (bus[NUM_CELLS].sel == SH_RECIP) ? (bus[NUM_CELLS].acc >> RECIP_BITS)
                                            : (bus[NUM_CELLS].acc >> FRAC_BITS);
    negq = bus[NUM_CELLS].neg && (q[LO_W-1:0] != '0);
    lim  = negq ? LIM_NEG : LIM_POS;
    sat  = q > lim;
    mag  = sat ? lim[DATA_W-1:0] : q[DATA_W-1:0];
    res_nxt.value = negq ? (~mag + 1'b1) : mag;
    res_nxt.ovf   = sat;
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= vld[NUM_CELLS];
    end
  end

endmodule

FILE: src/taylor_series_evaluator.sv
// Top level: term sequencer, reciprocal table and result register of the series evaluator.
//
// Usage:
//   in_*  : one item per argument; tdata = {term_count, arg_x}, x with FRAC_BITS fraction bits.
//   out_* : one item per input item; tdata = series_sum, tuser = overflow flag.
//   cfg_* : function_mode select (0 exp, 1 sinh, 2 cosh, 3 log1p), write while idle.
// Sequencing:
//   Every multiply runs through one shared pipelined multiplier (input stage, a row of
//   three 16-bit digit cells, a round/saturate stage) and each waits for the last.
//   Each item begins with an x*x multiply. Per term, the running term is then multiplied
//   by x (exp), -x (log1p; none on the first term) or x*x (sinh, cosh), and then by one
//   reciprocal (exp, log1p) or two (sinh, cosh). Terms added: n, the clamped term count
//   (n-1 for cosh). One item is in flight at a time; in_tready is high while the
//   sequencer is idle, also while a finished result still waits on out_*.
// Reset: rst_n (synchronous, low) clears the sequencer and output valid and sets exp mode.
// Stall: when out_tready is low the result holds; a finished item waits in the
// sequencer until the output register is free.
module taylor_series_evaluator
  import tse_pkg::*;
#(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [31:0] arg_x, [37:32] term_count, rest zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [47:0] series_sum
  output logic                 out_tuser,  // [0] overflow
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata
);

  localparam int K_W    = $clog2(MAX_TERMS + 2);
  localparam int RTBL_D = 2 * MAX_TERMS + 2;
  localparam int RIDX_W = $clog2(RTBL_D);
  localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;
  typedef enum logic [1:0] {PH_SQ, PH_MX, PH_R1, PH_R2} phase_t;
  typedef enum logic [1:0] {MODE_EXP, MODE_SINH, MODE_COSH, MODE_LOG1P} mode_t;

  state_t            state_r, state_nxt;
  phase_t            ph_r, ph_nxt;
  mode_t             mode_r, mode_nxt;
  logic [DATA_W-1:0] x_r, x_nxt, x2_r, x2_nxt, t_r, t_nxt, s_r, s_nxt;
  logic              ovf_r, ovf_nxt;
  logic [K_W-1:0]    k_r, k_nxt, n_r, n_nxt, k_inc;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_sum_r, out_sum_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic [RCP_W-1:0]  recip_tbl [RTBL_D];
  logic [RIDX_W-1:0] ridx, k1, k2;
  mul_req_t          req;
  logic              res_valid;
  mul_res_t          res;
  logic [DATA_W:0]   sum_ext;
  logic              add_ovf;
  logic [DATA_W-1:0] add_val;
  logic              term_end;
  logic [ARG_W-1:0]  in_arg;
  logic [CNT_W-1:0]  in_cnt;

  for (genvar g = 0; g < RTBL_D; g++) begin : g_rcp
    localparam logic [63:0] RV =
      ((64'd1 << RECIP_BITS) + 64'(g / 2)) / 64'((g == 0) ? 1 : g);
    assign recip_tbl[g] = RCP_W'(RV);
  end

  function automatic logic term_left(input logic [K_W-1:0] kk, input logic [K_W-1:0] nn,
                                     input mode_t m);
    term_left = (m == MODE_COSH) ? (kk < nn) : (kk <= nn);
  endfunction

  assign in_arg = in_tdata[ARG_W-1:0];
  assign in_cnt = in_tdata[ARG_W +: CNT_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_ovf_r;

  assign k_inc = k_r + 1'b1;
  assign k1    = RIDX_W'(k_r);
  assign k2    = RIDX_W'({k_r, 1'b0});

  always_comb begin
    case (ph_r)
      PH_R1:   ridx = (mode_r == MODE_SINH || mode_r == MODE_COSH) ? k2 : k1;
      PH_R2:   ridx = (mode_r == MODE_SINH) ? (k2 + 1'b1) : (k2 - 1'b1);
      default: ridx = '0;
    endcase
  end

  always_comb begin
    req.a   = (ph_r == PH_SQ) ? x_r : t_r;
    req.sel = SH_FRAC;
    case (ph_r)
      PH_SQ: req.b = x_r;
      PH_MX: begin
        case (mode_r)
          MODE_EXP:   req.b = x_r;
          MODE_LOG1P: req.b = ~x_r + 1'b1;
          default:    req.b = x2_r;
        endcase
      end
      default: begin
        req.b   = DATA_W'(recip_tbl[ridx]);
        req.sel = SH_RECIP;
      end
    endcase
  end

  tse_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(state_r == ST_ISSUE),
    .req      (req),
    .res_valid(res_valid),
    .res      (res)
  );

  assign sum_ext = {s_r[DATA_W-1], s_r} + {res.value[DATA_W-1], res.value};
  assign add_ovf = sum_ext[DATA_W] != sum_ext[DATA_W-1];
  assign add_val = add_ovf ? (sum_ext[DATA_W] ? SUM_MIN : SUM_MAX) : sum_ext[DATA_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    mode_nxt      = cfg_we ? mode_t'(cfg_wdata) : mode_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    out_ovf_nxt   = out_ovf_r;
    term_end      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = {{(DATA_W-ARG_W){in_arg[ARG_W-1]}}, in_arg};
          n_nxt     = (32'(in_cnt) > MAX_TERMS) ? K_W'(MAX_TERMS) : K_W'(in_cnt);
          k_nxt     = K_W'(1);
          ovf_nxt   = 1'b0;
          ph_nxt    = PH_SQ;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (res_valid) begin
          ovf_nxt   = ovf_r | res.ovf;
          state_nxt = ST_ISSUE;
          case (ph_r)
            PH_SQ: begin
              x2_nxt = res.value;
              case (mode_r)
                MODE_SINH: begin
                  t_nxt = x_r;
                  s_nxt = x_r;
                end
                MODE_LOG1P: begin
                  t_nxt = x_r;
                  s_nxt = '0;
                end
                default: begin
                  t_nxt = ONE;
                  s_nxt = ONE;
                end
              endcase
              ph_nxt = (mode_r == MODE_LOG1P) ? PH_R1 : PH_MX;
              if (!term_left(k_r, n_r, mode_r)) begin
                state_nxt = ST_DONE;
              end
            end
            PH_MX: begin
              t_nxt  = res.value;
              ph_nxt = PH_R1;
            end
            PH_R1: begin
              if (mode_r == MODE_SINH || mode_r == MODE_COSH) begin
                t_nxt  = res.value;
                ph_nxt = PH_R2;
              end else begin
                if (mode_r == MODE_EXP) begin
                  t_nxt = res.value;
                end
                term_end = 1'b1;
              end
            end
            default: begin
              t_nxt    = res.value;
              term_end = 1'b1;
            end
          endcase
          if (term_end) begin
            s_nxt   = add_val;
            ovf_nxt = ovf_r | res.ovf | add_ovf;
            k_nxt   = k_inc;
            ph_nxt  = PH_MX;
            if (!term_left(k_inc, n_r, mode_r)) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = s_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ph_r      <= ph_nxt;
    x_r       <= x_nxt;
    x2_r      <= x2_nxt;
    t_r       <= t_nxt;
    s_r       <= s_nxt;
    ovf_r     <= ovf_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    out_sum_r <= out_sum_nxt;
    out_ovf_r <= out_ovf_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_EXP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
